[design/chroma_key_alpha_macros.svh]
// Assertion macros for the chroma key alpha block.
`ifndef CHROMA_KEY_ALPHA_MACROS_SVH
`define CHROMA_KEY_ALPHA_MACROS_SVH

`ifndef ASSERT_OFF
// Check a condition at every clock edge out of reset.
`define CKA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("chroma_key_alpha: check failed");
// Check that an antecedent implies a consequent in the same cycle.
`define CKA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chroma_key_alpha: implication failed");
// Check that an antecedent implies a consequent in the next cycle.
`define CKA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chroma_key_alpha: next-cycle check failed");
`else
`define CKA_ASSERT_ALWAYS(lbl, cond)
`define CKA_ASSERT_IMPLY(lbl, ante, cons)
`define CKA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/cka_pkg.sv]
// Shared types, constants and helpers for the chroma key alpha block.
package cka_pkg;

    localparam int COMP_W     = 18;
    localparam int FRAC_W     = 15;
    localparam int ALPHA_W    = FRAC_W + 1;
    localparam int SQ_W       = 2 * COMP_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int QUO_W      = 32;
    localparam int RATIO_W    = QUO_W + 1;
    localparam int ROOT_W     = QUO_W / 2 + 1;
    localparam int ACC_W      = RATIO_W + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = QUO_W / 2 + 1;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COMP_W;
    localparam int TDATA_W    = ((3 * COMP_W + ALPHA_W + 7) / 8) * 8;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_CENTER_Z     = 3'd2,
        REG_CENTER_ALPHA = 3'd3,
        REG_EDGE_X       = 3'd4,
        REG_EDGE_Y       = 3'd5,
        REG_EDGE_Z       = 3'd6,
        REG_EDGE_ALPHA   = 3'd7
    } cfg_reg_t;

    // Per-item data that rides along the cell chain
    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic [ALPHA_W-1:0]       alpha;
        logic [ALPHA_W-1:0]       a_hi;
        logic [ALPHA_W-1:0]       a_lo;
        logic                     in_sphere;
        logic                     zero_out;
        logic                     zero_ratio;
        logic                     full;
    } side_t;

    function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] v);
        return (v > ALPHA_ONE) ? ALPHA_ONE : v;
    endfunction

    function automatic logic [COMP_W-1:0] abs_diff(input logic signed [COMP_W-1:0] a,
                                                   input logic signed [COMP_W-1:0] b);
        logic signed [COMP_W:0] d;
        logic signed [COMP_W:0] n;
        d = (COMP_W+1)'(a) - (COMP_W+1)'(b);
        n = -d;
        return d[COMP_W] ? n[COMP_W-1:0] : d[COMP_W-1:0];
    endfunction

endpackage

[design/cka_div_cell.sv]
// One restoring-division step cell of the ratio chain.
module cka_div_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cka_pkg::SUM_W-1:0]    in_rem,
    input  logic [cka_pkg::QUO_W-1:0]    in_q,
    input  logic [cka_pkg::SUM_W-1:0]    in_den,
    input  cka_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [cka_pkg::SUM_W-1:0]    out_rem,
    output logic [cka_pkg::QUO_W-1:0]    out_q,
    output logic [cka_pkg::SUM_W-1:0]    out_den,
    output cka_pkg::side_t               out_side
);
    import cka_pkg::*;

    logic                 valid_reg;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     q_reg, q_next;
    logic [SUM_W-1:0]     den_reg;
    side_t                side_reg;
    logic [SUM_W:0]       rem_shift;
    logic [SUM_W:0]       rem_sub;

    // Shift in one bit, subtract the divisor where it fits
    always_comb
    begin
        rem_shift = {in_rem, 1'b0};
        rem_sub   = rem_shift - {1'b0, in_den};
        if (rem_shift >= {1'b0, in_den})
        begin
            rem_next = rem_sub[SUM_W-1:0];
            q_next   = {in_q[QUO_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[SUM_W-1:0];
            q_next   = {in_q[QUO_W-2:0], 1'b0};
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

[design/cka_sqrt_cell.sv]
// One digit-by-digit square root step cell.
module cka_sqrt_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [cka_pkg::SHIFT_W-1:0]  shift,
    input  logic                         in_valid,
    input  logic [cka_pkg::RATIO_W-1:0]  in_v,
    input  logic [cka_pkg::ACC_W-1:0]    in_r,
    input  cka_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [cka_pkg::RATIO_W-1:0]  out_v,
    output logic [cka_pkg::ACC_W-1:0]    out_r,
    output cka_pkg::side_t               out_side
);
    import cka_pkg::*;

    logic                 valid_reg;
    logic [RATIO_W-1:0]   v_reg, v_next;
    logic [ACC_W-1:0]     r_reg, r_next;
    side_t                side_reg;
    logic [ACC_W-1:0]     bit_val;
    logic [ACC_W-1:0]     trial;
    logic [ACC_W-1:0]     v_diff;

    // Try the next root digit
    always_comb
    begin
        bit_val = ACC_W'(1) << shift;
        trial   = in_r + bit_val;
        v_diff  = {1'b0, in_v} - trial;
        if ({1'b0, in_v} >= trial)
        begin
            v_next = v_diff[RATIO_W-1:0];
            r_next = (in_r >> 1) + bit_val;
        end
        else
        begin
            v_next = in_v;
            r_next = in_r >> 1;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule

[design/chroma_key_alpha.sv]
// Top level of the chroma key alpha block: front stages, cell chains, alpha output.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | s_tvalid / s_tready    | s_tdata: in_x, in_y, in_z, in_alpha
//  output  | m_tvalid / m_tready    | m_tdata: out_x, out_y, out_z, out_alpha
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per clock while no result waits at the output; the path holds 4 front stages,
// 32 divider cells, 17 root cells and 2 alpha stages, set by the length of the chains.
// Reset clears all valid flags and loads the register reset values.
// The whole chain stalls together while a result waits at the output.
// Config writes are always ready and take effect in the next cycle.
module chroma_key_alpha (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // in_x [17:0], in_y [35:18], in_z [53:36], in_alpha [69:54], zero fill
    input  logic [cka_pkg::TDATA_W-1:0]    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x [17:0], out_y [35:18], out_z [53:36], out_alpha [69:54], zero fill
    output logic [cka_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cka_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cka_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cka_pkg::*;

    `include "chroma_key_alpha_macros.svh"

    // Configuration registers
    logic signed [COMP_W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic signed [COMP_W-1:0] edge_x_reg, edge_y_reg, edge_z_reg;
    logic [ALPHA_W-1:0]       center_alpha_reg, edge_alpha_reg;

    logic en;

    // Front stage registers
    logic                     a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    side_t                    a_side_reg, b_side_reg, c_side_reg, d_side_reg;
    logic [COMP_W-1:0]        a_mag_reg [6];
    logic [SQ_W-1:0]          b_sq_reg [6];
    logic [SUM_W-1:0]         c_dist_reg, c_rad_reg;
    logic [SUM_W-1:0]         d_rem_reg, d_den_reg;

    // Back stage registers
    logic                     e_valid_reg, f_valid_reg;
    side_t                    e_side_reg;
    logic [ALPHA_W-1:0]       e_factor_reg, e_factor_next;
    logic signed [COMP_W-1:0] f_x_reg, f_y_reg, f_z_reg;
    logic [ALPHA_W-1:0]       f_alpha_reg, f_alpha_next;

    // Chain links
    logic                     dv [DIV_STEPS+1];
    logic [SUM_W-1:0]         drem [DIV_STEPS+1];
    logic [QUO_W-1:0]         dq [DIV_STEPS+1];
    logic [SUM_W-1:0]         dden [DIV_STEPS+1];
    side_t                    dside [DIV_STEPS+1];
    logic                     sv [SQRT_STEPS+1];
    logic [RATIO_W-1:0]       svv [SQRT_STEPS+1];
    logic [ACC_W-1:0]         sr [SQRT_STEPS+1];
    side_t                    sside [SQRT_STEPS+1];

    logic signed [COMP_W-1:0] in_x, in_y, in_z;
    logic [ALPHA_W-1:0]       in_alpha;
    logic [ALPHA_W-1:0]       a1_sat, a2_sat;
    side_t                    a_side_next;
    side_t                    d_side_next;
    logic [ROOT_W-1:0]        root_s;
    logic [ALPHA_W-1:0]       alpha_span;
    logic [ALPHA_W+ROOT_W-1:0] span_prod;
    logic [2*ALPHA_W-1:0]     alpha_prod;

    // Stall the whole chain only while a result waits
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign in_x     = s_tdata[COMP_W-1:0];
    assign in_y     = s_tdata[2*COMP_W-1:COMP_W];
    assign in_z     = s_tdata[3*COMP_W-1:2*COMP_W];
    assign in_alpha = s_tdata[3*COMP_W+ALPHA_W-1:3*COMP_W];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
            center_alpha_reg <= ALPHA_ONE;
            edge_x_reg       <= '0;
            edge_y_reg       <= '0;
            edge_z_reg       <= '0;
            edge_alpha_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:     center_x_reg     <= cfg_data;
                REG_CENTER_Y:     center_y_reg     <= cfg_data;
                REG_CENTER_Z:     center_z_reg     <= cfg_data;
                REG_CENTER_ALPHA: center_alpha_reg <= cfg_data[ALPHA_W-1:0];
                REG_EDGE_X:       edge_x_reg       <= cfg_data;
                REG_EDGE_Y:       edge_y_reg       <= cfg_data;
                REG_EDGE_Z:       edge_z_reg       <= cfg_data;
                REG_EDGE_ALPHA:   edge_alpha_reg   <= cfg_data[ALPHA_W-1:0];
                default:          ;
            endcase
        end
    end

    // Saturate the alphas; when the edge alpha is larger, use both complements so a_hi >= a_lo
    always_comb
    begin
        a1_sat = sat_alpha(center_alpha_reg);
        a2_sat = sat_alpha(edge_alpha_reg);
        a_side_next = '0;
        a_side_next.x     = in_x;
        a_side_next.y     = in_y;
        a_side_next.z     = in_z;
        a_side_next.alpha = sat_alpha(in_alpha);
        if (a2_sat > a1_sat)
        begin
            a_side_next.a_hi = ALPHA_ONE - a1_sat;
            a_side_next.a_lo = ALPHA_ONE - a2_sat;
        end
        else
        begin
            a_side_next.a_hi = a1_sat;
            a_side_next.a_lo = a2_sat;
        end
    end

    // Classify the item before the divider chain
    always_comb
    begin
        d_side_next            = c_side_reg;
        d_side_next.in_sphere  = c_dist_reg <= c_rad_reg;
        d_side_next.full       = c_dist_reg >= c_rad_reg;
        d_side_next.zero_ratio = c_rad_reg == '0;
        d_side_next.zero_out   = c_side_reg.a_hi == c_side_reg.a_lo;
    end

    // Front valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Front payload: differences, squares, sums, divider setup
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg   <= a_side_next;
            a_mag_reg[0] <= abs_diff(in_x, center_x_reg);
            a_mag_reg[1] <= abs_diff(in_y, center_y_reg);
            a_mag_reg[2] <= abs_diff(in_z, center_z_reg);
            a_mag_reg[3] <= abs_diff(center_x_reg, edge_x_reg);
            a_mag_reg[4] <= abs_diff(center_y_reg, edge_y_reg);
            a_mag_reg[5] <= abs_diff(center_z_reg, edge_z_reg);

            b_side_reg <= a_side_reg;
            for (int i = 0; i < 6; i++)
            begin
                b_sq_reg[i] <= SQ_W'(a_mag_reg[i]) * SQ_W'(a_mag_reg[i]);
            end

            c_side_reg <= b_side_reg;
            c_dist_reg <= SUM_W'(b_sq_reg[0]) + SUM_W'(b_sq_reg[1]) + SUM_W'(b_sq_reg[2]);
            c_rad_reg  <= SUM_W'(b_sq_reg[3]) + SUM_W'(b_sq_reg[4]) + SUM_W'(b_sq_reg[5]);

            d_side_reg <= d_side_next;
            d_rem_reg  <= c_dist_reg;
            d_den_reg  <= c_rad_reg;
        end
    end

    // Divider chain: one quotient bit per cell
    assign dv[0]    = d_valid_reg;
    assign drem[0]  = d_rem_reg;
    assign dq[0]    = '0;
    assign dden[0]  = d_den_reg;
    assign dside[0] = d_side_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        cka_div_cell u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv[k]),
            .in_rem    (drem[k]),
            .in_q      (dq[k]),
            .in_den    (dden[k]),
            .in_side   (dside[k]),
            .out_valid (dv[k+1]),
            .out_rem   (drem[k+1]),
            .out_q     (dq[k+1]),
            .out_den   (dden[k+1]),
            .out_side  (dside[k+1])
        );
    end

    // Root chain: ratio saturates at one when the pixel sits on or beyond the rim
    assign sv[0]    = dv[DIV_STEPS];
    assign svv[0]   = dside[DIV_STEPS].full ? (RATIO_W'(1) << QUO_W)
                                            : {1'b0, dq[DIV_STEPS]};
    assign sr[0]    = '0;
    assign sside[0] = dside[DIV_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        cka_sqrt_cell u_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift     (SHIFT_W'(QUO_W - 2 * k)),
            .in_valid  (sv[k]),
            .in_v      (svv[k]),
            .in_r      (sr[k]),
            .in_side   (sside[k]),
            .out_valid (sv[k+1]),
            .out_v     (svv[k+1]),
            .out_r     (sr[k+1]),
            .out_side  (sside[k+1])
        );
    end

    // Ramp the factor from the low alpha toward the high alpha
    always_comb
    begin
        root_s        = sside[SQRT_STEPS].zero_ratio ? '0 : sr[SQRT_STEPS][ROOT_W-1:0];
        alpha_span    = sside[SQRT_STEPS].a_hi - sside[SQRT_STEPS].a_lo;
        span_prod     = (ALPHA_W+ROOT_W)'(alpha_span) * (ALPHA_W+ROOT_W)'(root_s);
        e_factor_next = sside[SQRT_STEPS].a_lo + span_prod[ALPHA_W+16-1:16];
    end

    // Scale the pixel alpha inside the sphere; pass it outside, zero it when the alphas match
    always_comb
    begin
        alpha_prod = (2*ALPHA_W)'(e_side_reg.alpha) * (2*ALPHA_W)'(e_factor_reg);
        priority if (!e_side_reg.in_sphere)
            f_alpha_next = e_side_reg.alpha;
        else if (e_side_reg.zero_out)
            f_alpha_next = '0;
        else
            f_alpha_next = alpha_prod[FRAC_W+ALPHA_W-1:FRAC_W];
    end

    // Back valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= sv[SQRT_STEPS];
            f_valid_reg <= e_valid_reg;
        end
    end

    // Back payload and output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_side_reg   <= sside[SQRT_STEPS];
            e_factor_reg <= e_factor_next;
            f_x_reg      <= e_side_reg.x;
            f_y_reg      <= e_side_reg.y;
            f_z_reg      <= e_side_reg.z;
            f_alpha_reg  <= f_alpha_next;
        end
    end

    assign m_tvalid = f_valid_reg;
    assign m_tdata  = TDATA_W'({f_alpha_reg, f_z_reg, f_y_reg, f_x_reg});

    // Checks on the datapath
    `CKA_ASSERT_IMPLY(a_out_alpha_range, m_tvalid, m_tdata[3*COMP_W+ALPHA_W-1:3*COMP_W] <= ALPHA_ONE)
    `CKA_ASSERT_IMPLY(a_factor_zero_ratio, e_valid_reg && e_side_reg.zero_ratio, e_factor_reg == e_side_reg.a_lo)
    `CKA_ASSERT_NEXT(a_out_follows_chain, en, m_tvalid == $past(e_valid_reg))
    `CKA_ASSERT_IMPLY(a_factor_bound, e_valid_reg, e_factor_reg <= e_side_reg.a_hi)

endmodule
